### rtl/core/particle_kick_drift_wrap_defines.svh
// assertion macros for the particle kick-drift-wrap block
`ifndef PARTICLE_KICK_DRIFT_WRAP_DEFINES_SVH
`define PARTICLE_KICK_DRIFT_WRAP_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication, sampled on clk, off during reset
`define PKD_ASSERT_IMP(lbl, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("pkd assertion failed");
// next-cycle implication, sampled on clk, off during reset
`define PKD_ASSERT_NEXT(lbl, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("pkd assertion failed");
`else
`define PKD_ASSERT_IMP(lbl, a, c)
`define PKD_ASSERT_NEXT(lbl, a, c)
`endif

`endif

### rtl/core/pkd_pkg.sv
// shared widths, register indexes and types of the particle integrator
package pkd_pkg;

    localparam int NUM_TYPES_DEF = 16;

    localparam int TYPE_W     = 4;
    localparam int FIX_W      = 32;
    localparam int DT_W       = 16;
    localparam int SCALE_W    = 18;
    localparam int BOX_W      = 31;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;

    // register indexes of the write port
    localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VEL_SCALE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_POS_SCALE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_X     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_Y     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_Z     = 3'd5;

    // reset values
    localparam logic [DT_W-1:0]    DT_RST    = 16'd0;
    localparam logic [SCALE_W-1:0] SCALE_RST = 18'd65536;
    localparam logic [BOX_W-1:0]   BOX_RST   = 31'd65536;

    // item kinds
    localparam logic KIND_UPDATE = 1'b0;
    localparam logic KIND_LOAD   = 1'b1;

    // pipeline control handed to the wrap units
    typedef struct packed {
        logic adv;
        logic vld;
    } pkd_ctl_t;

endpackage

### rtl/core/pkd_if.sv
// valid/ready channels carrying particle input and result beats
interface pkd_in_if import pkd_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     kind;
    logic [TYPE_W-1:0]        particle_type;
    logic [FIX_W-1:0]         inv_mass_value;
    logic signed [FIX_W-1:0]  pos_x;
    logic signed [FIX_W-1:0]  pos_y;
    logic signed [FIX_W-1:0]  pos_z;
    logic signed [FIX_W-1:0]  vel_x;
    logic signed [FIX_W-1:0]  vel_y;
    logic signed [FIX_W-1:0]  vel_z;
    logic signed [FIX_W-1:0]  force_x;
    logic signed [FIX_W-1:0]  force_y;
    logic signed [FIX_W-1:0]  force_z;

    modport source (
        output valid, kind, particle_type, inv_mass_value,
        output pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
        output force_x, force_y, force_z,
        input  ready
    );
    modport sink (
        input  valid, kind, particle_type, inv_mass_value,
        input  pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
        input  force_x, force_y, force_z,
        output ready
    );
endinterface

interface pkd_out_if import pkd_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [FIX_W-1:0]  new_pos_x;
    logic signed [FIX_W-1:0]  new_pos_y;
    logic signed [FIX_W-1:0]  new_pos_z;
    logic signed [FIX_W-1:0]  new_vel_x;
    logic signed [FIX_W-1:0]  new_vel_y;
    logic signed [FIX_W-1:0]  new_vel_z;
    logic                     jump_error;

    modport source (
        output valid, new_pos_x, new_pos_y, new_pos_z,
        output new_vel_x, new_vel_y, new_vel_z, jump_error,
        input  ready
    );
    modport sink (
        input  valid, new_pos_x, new_pos_y, new_pos_z,
        input  new_vel_x, new_vel_y, new_vel_z, jump_error,
        output ready
    );
endinterface

### rtl/core/particle_kick_drift_wrap.sv
// top level of the leapfrog particle integrator with periodic wrap
// Usage:
//   in_ch carries one beat per item. kind update pushes a particle through
//   the integrator; kind load writes inv_mass_value into the inverse mass
//   memory at particle_type and gives no result beat. Entries must be loaded
//   before a particle of that type is sent.
//   out_ch carries one result beat per particle: wrapped position, scaled
//   velocity and jump_error (some axis moved more than one box length).
//   Registers are written through cfg_we/cfg_index/cfg_data while idle.
// Timing:
//   One item per cycle sustained while out_ch is not stalled. A particle
//   passes a registered memory read, the velocity and step arithmetic, a
//   34-stage wrap of the input position, drift and pressure scaling, and a
//   37-stage wrap of the new position. The wraps resolve one remainder bit
//   per stage, which sets the latency.
// Reset and stall:
//   Reset clears registers to their defaults and empties the pipeline; the
//   inverse mass memory is not cleared. The result register drives out_ch;
//   while a result waits on out_ch.ready the whole pipeline holds and
//   in_ch.ready is low, otherwise a new beat is taken every cycle.
`include "particle_kick_drift_wrap_defines.svh"

module particle_kick_drift_wrap import pkd_pkg::*; #(
    parameter int NUM_TYPES = NUM_TYPES_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    pkd_in_if.sink                in_ch,
    pkd_out_if.source             out_ch
);

    localparam int IDX_W = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
    localparam int EXT_W = 12;
    localparam int W1_XW = FIX_W;
    localparam int W2_XW = FIX_W + 3;
    localparam int S1_W  = 2 * FIX_W;
    localparam int S2_W  = FIX_W + 1;

    function automatic logic signed [FIX_W-1:0] sat32(input logic signed [FIX_W+1:0] a);
        logic signed [FIX_W-1:0] r;
        if (a[FIX_W+1:FIX_W-1] == 3'b000 || a[FIX_W+1:FIX_W-1] == 3'b111)
            r = a[FIX_W-1:0];
        else if (a[FIX_W+1])
            r = {1'b1, {(FIX_W-1){1'b0}}};
        else
            r = {1'b0, {(FIX_W-1){1'b1}}};
        return r;
    endfunction

    // configuration registers
    logic [DT_W-1:0]    dt_reg;
    logic [SCALE_W-1:0] vel_scale_reg;
    logic [SCALE_W-1:0] pos_scale_reg;
    logic [BOX_W-1:0]   box_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dt_reg        <= DT_RST;
            vel_scale_reg <= SCALE_RST;
            pos_scale_reg <= SCALE_RST;
            box_reg[0]    <= BOX_RST;
            box_reg[1]    <= BOX_RST;
            box_reg[2]    <= BOX_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TIME_STEP: dt_reg        <= cfg_data[DT_W-1:0];
                REG_VEL_SCALE: vel_scale_reg <= cfg_data[SCALE_W-1:0];
                REG_POS_SCALE: pos_scale_reg <= cfg_data[SCALE_W-1:0];
                REG_BOX_X:     box_reg[0]    <= cfg_data[BOX_W-1:0];
                REG_BOX_Y:     box_reg[1]    <= cfg_data[BOX_W-1:0];
                REG_BOX_Z:     box_reg[2]    <= cfg_data[BOX_W-1:0];
                default:       ;
            endcase
        end
    end

    // handshake: the pipeline moves unless a result is held on out_ch
    logic adv;
    logic acc;
    logic load_acc;
    logic upd_acc;

    assign adv         = !(out_ch.valid && !out_ch.ready);
    assign in_ch.ready = adv;
    assign acc         = in_ch.valid && adv;
    assign load_acc    = acc && (in_ch.kind == KIND_LOAD);
    assign upd_acc     = acc && (in_ch.kind == KIND_UPDATE);

    // type index and range check
    logic [EXT_W-1:0] type_ext;
    logic [IDX_W-1:0] type_idx;
    logic             type_ok;

    assign type_ext = EXT_W'(in_ch.particle_type);
    assign type_idx = type_ext[IDX_W-1:0];
    assign type_ok  = type_ext < EXT_W'(NUM_TYPES);

    // inverse mass memory, one write and one registered read per cycle while the pipeline moves
    logic [FIX_W-1:0] im_mem [NUM_TYPES];
    logic [FIX_W-1:0] im_rd_reg;

    always_ff @(posedge clk)
    begin
        if (load_acc && type_ok)
            im_mem[type_idx] <= in_ch.inv_mass_value;
        if (adv)
            im_rd_reg <= im_mem[type_idx];
    end

    // valid chain of the arithmetic stages
    logic s0_vld_reg;
    logic s0_tok_reg;
    logic v_vld_reg [7];
    logic w8_vld_reg;
    logic w9_vld_reg;
    logic w1_vld [3];
    logic w2_vld [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_vld_reg <= 1'b0;
            for (int i = 0; i < 7; i++)
                v_vld_reg[i] <= 1'b0;
            w8_vld_reg <= 1'b0;
            w9_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s0_vld_reg   <= upd_acc;
            v_vld_reg[0] <= s0_vld_reg;
            for (int i = 1; i < 7; i++)
                v_vld_reg[i] <= v_vld_reg[i-1];
            w8_vld_reg <= w1_vld[0];
            w9_vld_reg <= w8_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            s0_tok_reg <= type_ok;
    end

    logic [FIX_W-1:0] im_eff;
    assign im_eff = s0_tok_reg ? im_rd_reg : '0;

    logic signed [FIX_W-1:0] in_pos [3];
    logic signed [FIX_W-1:0] in_vel [3];
    logic signed [FIX_W-1:0] in_frc [3];

    assign in_pos[0] = in_ch.pos_x;
    assign in_pos[1] = in_ch.pos_y;
    assign in_pos[2] = in_ch.pos_z;
    assign in_vel[0] = in_ch.vel_x;
    assign in_vel[1] = in_ch.vel_y;
    assign in_vel[2] = in_ch.vel_z;
    assign in_frc[0] = in_ch.force_x;
    assign in_frc[1] = in_ch.force_y;
    assign in_frc[2] = in_ch.force_z;

    logic signed [FIX_W-1:0] w2_res  [3];
    logic signed [FIX_W-1:0] out_vn  [3];
    logic                    w2_jmp  [3];
    logic                    out_j1  [3];
    pkd_ctl_t                w1_ctl;
    pkd_ctl_t                w2_ctl;

    assign w1_ctl = '{adv: adv, vld: v_vld_reg[6]};
    assign w2_ctl = '{adv: adv, vld: w9_vld_reg};

    for (genvar ax = 0; ax < 3; ax++)
    begin : g_axis
        logic signed [FIX_W-1:0]   s0_pos_reg, s0_vel_reg, s0_frc_reg;
        logic signed [FIX_W-1:0]   v1_pos_reg, v1_vel_reg;
        logic signed [63:0]        v1_prod_reg;
        logic signed [FIX_W-1:0]   v2_pos_reg, v2_vel_reg;
        logic signed [63:0]        v2_hp_reg;
        logic [15:0]               v2_lf_reg;
        logic signed [FIX_W-1:0]   v3_pos_reg, v3_vel_reg, v3_dv_reg;
        logic signed [FIX_W-1:0]   v4_pos_reg, v4_s_reg;
        logic signed [FIX_W-1:0]   v5_pos_reg;
        logic signed [49:0]        v5_sv_reg;
        logic signed [FIX_W-1:0]   v6_pos_reg, v6_vn_reg;
        logic signed [FIX_W-1:0]   v7_pos_reg, v7_vn_reg;
        logic signed [47:0]        v7_dd_reg;
        logic signed [FIX_W:0]     w8_q_reg;
        logic signed [FIX_W-1:0]   w8_vn_reg;
        logic                      w8_j1_reg;
        logic signed [50:0]        w9_pp_reg;
        logic signed [FIX_W-1:0]   w9_vn_reg;
        logic                      w9_j1_reg;

        logic signed [64:0]        prod_full;
        logic signed [64:0]        hp_full;
        logic [31:0]               lf_full;
        logic signed [64:0]        t_sum;
        logic signed [FIX_W+1:0]   s_sum;
        logic signed [50:0]        sv_full;
        logic signed [48:0]        dd_full;
        logic signed [51:0]        pp_full;

        logic signed [FIX_W-1:0]   w1_res;
        logic                      w1_jmp;
        logic [S1_W-1:0]           w1_side;
        logic [S1_W-1:0]           w1_side_o;
        logic [S2_W-1:0]           w2_side;

        // arithmetic of each stage
        always_comb
        begin
            prod_full = $signed(s0_frc_reg) * $signed({1'b0, im_eff});
            hp_full   = $signed(v1_prod_reg[63:16]) * $signed({1'b0, dt_reg});
            lf_full   = v1_prod_reg[15:0] * dt_reg;
            t_sum     = 65'(v2_hp_reg) + $signed({49'd0, v2_lf_reg});
            s_sum     = (FIX_W+2)'(v3_vel_reg) + (FIX_W+2)'(v3_dv_reg);
            sv_full   = $signed(v4_s_reg) * $signed({1'b0, vel_scale_reg});
            dd_full   = $signed(v6_vn_reg) * $signed({1'b0, dt_reg});
            pp_full   = $signed(w8_q_reg) * $signed({1'b0, pos_scale_reg});
        end

        // velocity kick, velocity scaling and step length
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                s0_pos_reg  <= in_pos[ax];
                s0_vel_reg  <= in_vel[ax];
                s0_frc_reg  <= in_frc[ax];
                v1_pos_reg  <= s0_pos_reg;
                v1_vel_reg  <= s0_vel_reg;
                v1_prod_reg <= prod_full[63:0];
                v2_pos_reg  <= v1_pos_reg;
                v2_vel_reg  <= v1_vel_reg;
                v2_hp_reg   <= hp_full[63:0];
                v2_lf_reg   <= lf_full[31:16];
                v3_pos_reg  <= v2_pos_reg;
                v3_vel_reg  <= v2_vel_reg;
                v3_dv_reg   <= sat32($signed(t_sum[64:31]) >>> 1);
                v4_pos_reg  <= v3_pos_reg;
                v4_s_reg    <= sat32(s_sum);
                v5_pos_reg  <= v4_pos_reg;
                v5_sv_reg   <= sv_full[49:0];
                v6_pos_reg  <= v5_pos_reg;
                v6_vn_reg   <= sat32(v5_sv_reg[49:16]);
                v7_pos_reg  <= v6_pos_reg;
                v7_vn_reg   <= v6_vn_reg;
                v7_dd_reg   <= dd_full[47:0];
            end
        end

        assign w1_side = {v7_vn_reg, v7_dd_reg[47:16]};

        // wrap of the input position
        pkd_wrap #(
            .XW     (W1_XW),
            .SIDE_W (S1_W)
        ) u_wrap_in (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (w1_ctl),
            .x        (v7_pos_reg),
            .box      (box_reg[ax]),
            .side     (w1_side),
            .vld      (w1_vld[ax]),
            .res      (w1_res),
            .jump     (w1_jmp),
            .side_out (w1_side_o)
        );

        // drift and position scaling
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                w8_q_reg  <= (FIX_W+1)'(w1_res) + (FIX_W+1)'($signed(w1_side_o[FIX_W-1:0]));
                w8_vn_reg <= w1_side_o[S1_W-1:FIX_W];
                w8_j1_reg <= w1_jmp;
                w9_pp_reg <= pp_full[50:0];
                w9_vn_reg <= w8_vn_reg;
                w9_j1_reg <= w8_j1_reg;
            end
        end

        assign w2_side = {w9_vn_reg, w9_j1_reg};

        logic [S2_W-1:0] w2_side_o;

        // wrap of the new position
        pkd_wrap #(
            .XW     (W2_XW),
            .SIDE_W (S2_W)
        ) u_wrap_out (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (w2_ctl),
            .x        (w9_pp_reg[50:16]),
            .box      (box_reg[ax]),
            .side     (w2_side),
            .vld      (w2_vld[ax]),
            .res      (w2_res[ax]),
            .jump     (w2_jmp[ax]),
            .side_out (w2_side_o)
        );

        assign out_vn[ax] = w2_side_o[S2_W-1:1];
        assign out_j1[ax] = w2_side_o[0];
    end

    // result beat straight from the final wrap registers
    assign out_ch.valid      = w2_vld[0] && w2_vld[1] && w2_vld[2];
    assign out_ch.new_pos_x  = w2_res[0];
    assign out_ch.new_pos_y  = w2_res[1];
    assign out_ch.new_pos_z  = w2_res[2];
    assign out_ch.new_vel_x  = out_vn[0];
    assign out_ch.new_vel_y  = out_vn[1];
    assign out_ch.new_vel_z  = out_vn[2];
    assign out_ch.jump_error = w2_jmp[0] || w2_jmp[1] || w2_jmp[2]
                            || out_j1[0] || out_j1[1] || out_j1[2];

    // a load beat never enters the arithmetic pipeline
    `PKD_ASSERT_NEXT(a_load_no_entry, load_acc, !s0_vld_reg)
    // a held result freezes the pipeline entry
    `PKD_ASSERT_NEXT(a_stall_holds_entry, !adv, $stable(s0_vld_reg))
    // the three axis lanes run in lockstep
    `PKD_ASSERT_IMP(a_axes_lockstep, w2_vld[0] || w2_vld[1] || w2_vld[2] || w1_vld[0],
        (w2_vld[0] == w2_vld[1]) && (w2_vld[1] == w2_vld[2]) && (w1_vld[0] == w1_vld[2]))

endmodule

### rtl/core/pkd_wrap.sv
// pipelined periodic wrap: floor modulo by the box length, one bit per stage
module pkd_wrap import pkd_pkg::*; #(
    parameter int XW     = 32,
    parameter int SIDE_W = 1
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  pkd_ctl_t                 ctl,
    input  logic signed [XW-1:0]     x,
    input  logic [BOX_W-1:0]         box,
    input  logic [SIDE_W-1:0]        side,
    output logic                     vld,
    output logic signed [FIX_W-1:0]  res,
    output logic                     jump,
    output logic [SIDE_W-1:0]        side_out
);

    // stage 0 is the sign split, stages 1..XW each take one dividend bit
    logic              vld_reg  [XW+1];
    logic              neg_reg  [XW+1];
    logic              jmp_reg  [XW+1];
    logic [XW-1:0]     mag_reg  [XW+1];
    logic [BOX_W-1:0]  rem_reg  [XW+1];
    logic [FIX_W-1:0]  xlo_reg  [XW+1];
    logic [SIDE_W-1:0] side_reg [XW+1];

    logic              neg_in;
    logic [XW-1:0]     mag_in;
    logic [XW:0]       box_ext;
    logic [XW:0]       box2_ext;
    logic              jmp_in;

    // magnitude and the more-than-one-box test
    always_comb
    begin
        neg_in   = x[XW-1];
        mag_in   = neg_in ? XW'(-x) : XW'(x);
        box_ext  = (XW+1)'(box);
        box2_ext = (XW+1)'({box, 1'b0});
        if (box == '0)
            jmp_in = 1'b0;
        else if (neg_in)
            jmp_in = {1'b0, mag_in} > box_ext;
        else
            jmp_in = {1'b0, mag_in} >= box2_ext;
    end

    // entry stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else if (ctl.adv)
            vld_reg[0] <= ctl.vld;
    end

    // entry stage payload
    always_ff @(posedge clk)
    begin
        if (ctl.adv)
        begin
            neg_reg[0]  <= neg_in;
            jmp_reg[0]  <= jmp_in;
            mag_reg[0]  <= mag_in;
            rem_reg[0]  <= '0;
            xlo_reg[0]  <= x[FIX_W-1:0];
            side_reg[0] <= side;
        end
    end

    // restoring remainder stages
    for (genvar k = 1; k <= XW; k++)
    begin : g_stage
        logic [BOX_W:0]   trial;
        logic [BOX_W:0]   diff;
        logic [BOX_W-1:0] rem_next;

        always_comb
        begin
            trial    = {rem_reg[k-1], mag_reg[k-1][XW-1]};
            diff     = trial - {1'b0, box};
            rem_next = (trial >= {1'b0, box}) ? diff[BOX_W-1:0] : trial[BOX_W-1:0];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else if (ctl.adv)
                vld_reg[k] <= vld_reg[k-1];
        end

        always_ff @(posedge clk)
        begin
            if (ctl.adv)
            begin
                neg_reg[k]  <= neg_reg[k-1];
                jmp_reg[k]  <= jmp_reg[k-1];
                mag_reg[k]  <= {mag_reg[k-1][XW-2:0], 1'b0};
                rem_reg[k]  <= rem_next;
                xlo_reg[k]  <= xlo_reg[k-1];
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    // floor correction for negative inputs, pass-through for a zero box
    logic                    out_vld_reg;
    logic signed [FIX_W-1:0] res_reg;
    logic signed [FIX_W-1:0] res_next;
    logic                    jump_reg;
    logic [SIDE_W-1:0]       side_out_reg;

    always_comb
    begin
        if (box == '0)
            res_next = xlo_reg[XW];
        else if (neg_reg[XW] && (rem_reg[XW] != '0))
            res_next = {1'b0, box - rem_reg[XW]};
        else
            res_next = {1'b0, rem_reg[XW]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (ctl.adv)
            out_vld_reg <= vld_reg[XW];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.adv)
        begin
            res_reg      <= res_next;
            jump_reg     <= jmp_reg[XW];
            side_out_reg <= side_reg[XW];
        end
    end

    assign vld      = out_vld_reg;
    assign res      = res_reg;
    assign jump     = jump_reg;
    assign side_out = side_out_reg;

endmodule

### bench/tb_top.sv
// self-checking bench for the particle kick-drift-wrap integrator
module tb_top;
    import pkd_pkg::*;

    localparam int  DRAIN_CYCLES = 100;
    localparam int  CYCLE_LIMIT  = 1000000;

    typedef struct {
        logic                    kind;
        logic [TYPE_W-1:0]       ptype;
        logic [FIX_W-1:0]        inv_mass;
        logic signed [FIX_W-1:0] pos [3];
        logic signed [FIX_W-1:0] vel [3];
        logic signed [FIX_W-1:0] frc [3];
    } particle_t;

    typedef struct {
        logic signed [FIX_W-1:0] pos [3];
        logic signed [FIX_W-1:0] vel [3];
        logic                    jump;
    } motion_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    pkd_in_if  in_ch ();
    pkd_out_if out_ch ();

    particle_kick_drift_wrap DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // shadow of the block's registers and inverse mass memory
    logic [DT_W-1:0]     dt_q;
    logic [SCALE_W-1:0]  vscale_q;
    logic [SCALE_W-1:0]  pscale_q;
    logic [BOX_W-1:0]    box_q [3];
    logic [FIX_W-1:0]    inv_mass_mem [NUM_TYPES_DEF];
    bit                  mass_loaded [NUM_TYPES_DEF];

    motion_t pending_motion [$];

    int  errors = 0;
    int  cycles = 0;
    int  idle_pct = 0;
    int  stall_pct = 0;
    bit  hold_off = 1'b0;
    int  n_particles = 0;
    int  n_loads = 0;
    int  n_checked = 0;
    int  n_jumps = 0;
    int  n_configs = 0;

    always #6 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // fixed-point helpers, floor rounding
    function automatic longint fdiv(longint x, longint b);
        longint q;
        q = x / b;
        if ((x % b) != 0 && x < 0)
            q--;
        return q;
    endfunction

    function automatic longint sat32(longint x);
        if (x > 64'sd2147483647)
            return 64'sd2147483647;
        if (x < -64'sd2147483648)
            return -64'sd2147483648;
        return x;
    endfunction

    function automatic longint wrap_coord(longint x, logic [BOX_W-1:0] box, inout bit jump);
        longint b;
        longint n;
        b = longint'({33'b0, box});
        if (b == 0)
            return x;
        n = fdiv(x, b);
        if (n > 1 || n < -1)
            jump = 1'b1;
        return x - n * b;
    endfunction

    // one axis of kick, thermostat, drift, barostat and wrap
    function automatic void kick_drift_axis(
        input  logic signed [FIX_W-1:0] p_in, v_in, f_in,
        input  logic [FIX_W-1:0]        im,
        input  logic [BOX_W-1:0]        box,
        inout  bit                      jump,
        output logic signed [FIX_W-1:0] p_out, v_out
    );
        longint r0, dt, prod, hi, lo, t, dv, s, vn, d, p;
        r0   = wrap_coord(longint'(p_in), box, jump);
        dt   = longint'({48'b0, dt_q});
        prod = longint'(f_in) * longint'({32'b0, im});
        hi   = fdiv(prod, 65536);
        lo   = prod - hi * 65536;
        t    = hi * dt + fdiv(lo * dt, 65536);
        dv   = fdiv(t, 64'sh100000000);
        s    = sat32(longint'(v_in) + sat32(dv));
        vn   = sat32(fdiv(s * longint'({46'b0, vscale_q}), 65536));
        d    = fdiv(vn * dt, 65536);
        p    = fdiv((r0 + d) * longint'({46'b0, pscale_q}), 65536);
        p    = wrap_coord(p, box, jump);
        p_out = p[31:0];
        v_out = vn[31:0];
    endfunction

    // apply one accepted beat to the shadow state, queue any result
    function automatic void integrate_particle(particle_t it);
        motion_t m;
        bit      jump;
        jump = 1'b0;
        if (it.kind == KIND_LOAD)
        begin
            inv_mass_mem[it.ptype] = it.inv_mass;
            mass_loaded[it.ptype]  = 1'b1;
            n_loads++;
            return;
        end
        for (int a = 0; a < 3; a++)
            kick_drift_axis(it.pos[a], it.vel[a], it.frc[a], inv_mass_mem[it.ptype],
                            box_q[a], jump, m.pos[a], m.vel[a]);
        m.jump = jump;
        pending_motion.push_back(m);
        n_particles++;
    endfunction

    // result checker
    task automatic cmp_field(string name, logic [FIX_W-1:0] exp_v, logic [FIX_W-1:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s mismatch: expected %h, got %h", name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        motion_t m;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_motion.size() == 0)
            begin
                $error("result beat with no particle outstanding");
                errors++;
            end
            else
            begin
                m = pending_motion.pop_front();
                cmp_field("new_pos_x", m.pos[0], out_ch.new_pos_x);
                cmp_field("new_pos_y", m.pos[1], out_ch.new_pos_y);
                cmp_field("new_pos_z", m.pos[2], out_ch.new_pos_z);
                cmp_field("new_vel_x", m.vel[0], out_ch.new_vel_x);
                cmp_field("new_vel_y", m.vel[1], out_ch.new_vel_y);
                cmp_field("new_vel_z", m.vel[2], out_ch.new_vel_z);
                cmp_field("jump_error", {31'b0, m.jump}, {31'b0, out_ch.jump_error});
                n_checked++;
                if (m.jump)
                    n_jumps++;
            end
        end
    end

    // receiver stalls
    always @(negedge clk)
        out_ch.ready <= rst_n && !hold_off && ($urandom_range(99) >= stall_pct);

    // drive one beat, wait for acceptance, then predict
    task automatic send_beat(particle_t it);
        while ($urandom_range(99) < idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.kind           <= it.kind;
        in_ch.particle_type  <= it.ptype;
        in_ch.inv_mass_value <= it.inv_mass;
        in_ch.pos_x   <= it.pos[0];
        in_ch.pos_y   <= it.pos[1];
        in_ch.pos_z   <= it.pos[2];
        in_ch.vel_x   <= it.vel[0];
        in_ch.vel_y   <= it.vel[1];
        in_ch.vel_z   <= it.vel[2];
        in_ch.force_x <= it.frc[0];
        in_ch.force_y <= it.frc[1];
        in_ch.force_z <= it.frc[2];
        do
            @(posedge clk);
        while (!in_ch.ready);
        integrate_particle(it);
        @(negedge clk);
    endtask

    // stop offering, wait for every result, let loads flush through
    task automatic drain();
        in_ch.valid <= 1'b0;
        wait (pending_motion.size() == 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        case (idx)
            REG_TIME_STEP: dt_q     = val[DT_W-1:0];
            REG_VEL_SCALE: vscale_q = val[SCALE_W-1:0];
            REG_POS_SCALE: pscale_q = val[SCALE_W-1:0];
            REG_BOX_X:     box_q[0] = val[BOX_W-1:0];
            REG_BOX_Y:     box_q[1] = val[BOX_W-1:0];
            REG_BOX_Z:     box_q[2] = val[BOX_W-1:0];
            default: ;
        endcase
        n_configs++;
    endtask

    task automatic set_regs(int dt, int vs, int ps, int bx, int by, int bz);
        drain();
        write_reg(REG_TIME_STEP, CFG_DATA_W'(dt));
        write_reg(REG_VEL_SCALE, CFG_DATA_W'(vs));
        write_reg(REG_POS_SCALE, CFG_DATA_W'(ps));
        write_reg(REG_BOX_X, CFG_DATA_W'(bx));
        write_reg(REG_BOX_Y, CFG_DATA_W'(by));
        write_reg(REG_BOX_Z, CFG_DATA_W'(bz));
        cfg_we <= 1'b0;
    endtask

    function automatic int pick_box();
        case ($urandom_range(5))
            0: return 1;
            1: return 65536;
            2: return 32'h7fffffff;
            3: return $urandom_range(32'h7fffffff, 1);
            default: return $urandom_range(32'h00400000, 32'h00001000);
        endcase
    endfunction

    function automatic int pick_scale();
        case ($urandom_range(4))
            0: return 0;
            1: return 18'h3ffff;
            2: return 65536;
            default: return $urandom_range(18'h3ffff);
        endcase
    endfunction

    function automatic int pick_dt();
        case ($urandom_range(3))
            0: return 0;
            1: return 16'hffff;
            default: return $urandom_range(16'hffff);
        endcase
    endfunction

    // coordinates mostly near the box, some full range
    function automatic logic [FIX_W-1:0] pick_coord(logic [BOX_W-1:0] box);
        case ($urandom_range(3))
            0: return $urandom();
            1: return $urandom_range({1'b0, box}) - ($urandom_range(1) ? {1'b0, box} : 32'd0);
            default: return $urandom_range({1'b0, box});
        endcase
    endfunction

    function automatic logic [FIX_W-1:0] pick_value();
        case ($urandom_range(3))
            0: return $urandom();
            1: return $urandom_range(32'h00100000) - 32'h00080000;
            2: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
            default: return $urandom_range(32'h01000000) - 32'h00800000;
        endcase
    endfunction

    function automatic particle_t rand_particle();
        particle_t it;
        it.kind     = ($urandom_range(19) == 0) ? KIND_LOAD : KIND_UPDATE;
        it.inv_mass = ($urandom_range(3) == 0) ? $urandom() : $urandom_range(32'h00040000);
        do
            it.ptype = TYPE_W'($urandom_range(NUM_TYPES_DEF - 1));
        while (it.kind == KIND_UPDATE && !mass_loaded[it.ptype]);
        for (int a = 0; a < 3; a++)
        begin
            it.pos[a] = pick_coord(box_q[a]);
            it.vel[a] = pick_value();
            it.frc[a] = pick_value();
        end
        return it;
    endfunction

    function automatic particle_t make_particle(logic [TYPE_W-1:0] t, logic [FIX_W-1:0] p,
                                                logic [FIX_W-1:0] v, logic [FIX_W-1:0] f);
        particle_t it;
        it.kind     = KIND_UPDATE;
        it.ptype    = t;
        it.inv_mass = '0;
        for (int a = 0; a < 3; a++)
        begin
            it.pos[a] = p;
            it.vel[a] = v;
            it.frc[a] = f;
        end
        return it;
    endfunction

    // fill the whole inverse mass memory, extremes included
    task automatic test_mass_load();
        particle_t it;
        it = make_particle(0, 0, 0, 0);
        it.kind = KIND_LOAD;
        for (int t = 0; t < NUM_TYPES_DEF; t++)
        begin
            it.ptype    = TYPE_W'(t);
            it.inv_mass = (t == 0) ? 32'h0 : (t == 1) ? 32'hffffffff : $urandom();
            send_beat(it);
        end
    endtask

    // field extremes, saturation, large jumps and unwrapped axes
    task automatic test_extremes();
        particle_t it;
        set_regs(16'hffff, 18'h3ffff, 18'h3ffff, 32'h00100000, 32'h7fffffff, 1);
        send_beat(make_particle(1, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
        send_beat(make_particle(1, 32'h80000000, 32'h80000000, 32'h80000000));
        send_beat(make_particle(1, 32'h80000000, 32'h7fffffff, 32'h80000000));
        send_beat(make_particle(0, 32'h00000000, 32'hffffffff, 32'h7fffffff));
        it = make_particle(2, 32'h00050000, 32'h00010000, 32'hfff00000);
        it.pos[0] = 32'hfff00000;
        send_beat(it);
        // zero box length on x and z leaves those axes alone
        set_regs(16'h1000, 65536, 65536, 0, 65536, 0);
        send_beat(make_particle(3, 32'h12345678, 32'h00100000, 32'h00200000));
        send_beat(make_particle(3, 32'h80000000, 32'h7fffffff, 32'h80000000));
        // reload one entry and use it right away
        it = make_particle(5, 0, 0, 0);
        it.kind     = KIND_LOAD;
        it.inv_mass = 32'h00020000;
        send_beat(it);
        send_beat(make_particle(5, 32'h00008000, 32'h00001000, 32'h00010000));
    endtask

    task automatic test_random(int n_items, int idle, int stall);
        set_regs(pick_dt(), pick_scale(), pick_scale(), pick_box(), pick_box(), pick_box());
        idle_pct  = idle;
        stall_pct = stall;
        for (int i = 0; i < n_items; i++)
            send_beat(rand_particle());
        idle_pct  = 0;
        stall_pct = 0;
    endtask

    // long receiver hold while the sender keeps pushing, then a full pause
    task automatic test_backpressure();
        set_regs(16'h4000, 65536, 65536, 32'h00200000, 32'h00300000, 32'h00400000);
        idle_pct  = 0;
        stall_pct = 0;
        fork
            begin
                hold_off = 1'b1;
                repeat (400) @(posedge clk);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 200; i++)
                send_beat(rand_particle());
        join
        drain();
        for (int i = 0; i < 20; i++)
            send_beat(rand_particle());
    endtask

    initial
    begin
        dt_q     = DT_RST;
        vscale_q = SCALE_RST;
        pscale_q = SCALE_RST;
        for (int a = 0; a < 3; a++)
            box_q[a] = BOX_RST;
        for (int t = 0; t < NUM_TYPES_DEF; t++)
        begin
            inv_mass_mem[t] = '0;
            mass_loaded[t]  = 1'b0;
        end
        in_ch.valid          = 1'b0;
        in_ch.kind           = KIND_UPDATE;
        in_ch.particle_type  = '0;
        in_ch.inv_mass_value = '0;
        in_ch.pos_x = '0;
        in_ch.pos_y = '0;
        in_ch.pos_z = '0;
        in_ch.vel_x = '0;
        in_ch.vel_y = '0;
        in_ch.vel_z = '0;
        in_ch.force_x = '0;
        in_ch.force_y = '0;
        in_ch.force_z = '0;
        out_ch.ready  = 1'b0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_mass_load();
        test_extremes();
        test_random(300, 0, 0);
        test_random(150, 88, 0);
        test_random(150, 0, 88);
        test_random(250, 25, 25);
        test_random(250, 0, 0);
        test_backpressure();
        drain();

        $display("covered %0d particles and %0d mass loads over %0d register writes",
                 n_particles, n_loads, n_configs);
        $display("checked %0d result beats, %0d with a jump flag", n_checked, n_jumps);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/pkd_pkg.sv
rtl/core/pkd_if.sv
rtl/core/pkd_wrap.sv
rtl/core/particle_kick_drift_wrap.sv
bench/tb_top.sv
